### rtl/core/mlrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlrq_pkg
// Shared types for the multilevel ready queue scheduler.
// ----------------------------------------------------------------------------
package mlrq_pkg;

    localparam int unsigned PID_W  = 6;
    localparam int unsigned PRIO_W = 4;
    localparam int unsigned TICK_W = 16;

    typedef enum logic {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } t_func;

    typedef struct packed {
        logic              func;
        logic [PID_W-1:0]  process_id;
        logic [PRIO_W-1:0] priority_req;
        logic [TICK_W-1:0] ticks_rem;
        logic [TICK_W-1:0] quantum;
        logic [PID_W-1:0]  current_id;
        logic              current_valid;
    } t_req;

    typedef struct packed {
        logic [PRIO_W-1:0] queue_used;
        logic              placed_front;
        logic [TICK_W-1:0] ticks_after;
        logic              removed;
        logic [PID_W-1:0]  next_id;
        logic              next_valid;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the request
        logic enq;       // apply enqueue
        logic walk_adv;  // take link read data, advance
        logic unlink;    // apply unlink of found node
        logic pick_clr;  // reset pick scan
        logic pick_step; // scan one queue
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic req_ok;
        logic is_deq;
        logic node_ok;
        logic node_hit;
        logic walk_end;
        logic need_pick;
        logic pick_end;
    } t_sts;

endpackage

### rtl/core/mlrq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlrq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlrq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/mlrq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlrq_dp
// Datapath: queue head/tail tables, link RAM, walk and pick registers.
// ----------------------------------------------------------------------------
module mlrq_dp #(
    parameter int unsigned NUM_QUEUES = 16,
    parameter int unsigned NUM_PROCS  = 64,
    parameter int unsigned TICK_BITS  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mlrq_pkg::t_req i_req,
    input  mlrq_pkg::t_cmd i_cmd,
    output mlrq_pkg::t_sts o_sts,
    output mlrq_pkg::t_rsp o_rsp
);
    import mlrq_pkg::*;

    localparam int unsigned PW = $clog2(NUM_PROCS);
    localparam int unsigned QW = $clog2(NUM_QUEUES);
    localparam int unsigned EW = PW + 1;   // valid bit plus index

    t_req r_req;
    logic [EW-1:0] r_head [NUM_QUEUES];
    logic [EW-1:0] r_tail [NUM_QUEUES];
    logic [EW-1:0] r_next_run, r_last_ref;
    logic [EW-1:0] r_prev, r_node;
    logic [PW:0]   r_steps;
    logic [QW:0]   r_pq;
    logic          r_removed;

    logic          w_we;
    logic [PW-1:0] w_waddr, w_raddr;
    logic [EW-1:0] w_wdata, w_rdata;

    // tail append: link of the old tail, written the cycle after enq
    logic          r_tl_we;
    logic [PW-1:0] r_tl_addr;
    logic [EW-1:0] r_tl_data;

    mlrq_ram #(.WIDTH(EW), .DEPTH(NUM_PROCS)) u_link (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    logic [PW-1:0] w_pid;
    logic [QW-1:0] w_q;
    logic [EW-1:0] w_me;
    logic          w_has_time;
    logic [TICK_BITS-1:0] w_ticks_in, w_quant_in;
    logic          w_pid_ok, w_q_ok;

    assign w_pid_ok   = 32'(r_req.process_id) < NUM_PROCS;
    assign w_q_ok     = 32'(r_req.priority_req) < NUM_QUEUES;
    assign w_pid      = PW'(r_req.process_id);
    assign w_q        = QW'(r_req.priority_req);
    assign w_me       = {1'b1, w_pid};
    assign w_ticks_in = TICK_BITS'(r_req.ticks_rem);
    assign w_quant_in = TICK_BITS'(r_req.quantum);
    assign w_has_time = w_ticks_in != '0;

    // link RAM read/write selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_pid;
        w_wdata = '0;
        w_raddr = r_node[PW-1:0];
        if (i_cmd.enq) begin
            w_we = 1'b1;
            if (!r_head[w_q][EW-1]) begin
                w_wdata = '0;
            end else if (w_has_time) begin
                w_wdata = r_head[w_q];
            end else begin
                w_wdata = '0;
            end
        end else if (i_cmd.unlink) begin
            // r_node holds the found node; w_rdata holds its successor
            w_we    = r_prev[EW-1];
            w_waddr = r_prev[PW-1:0];
            w_wdata = w_rdata;
        end else if (r_tl_we) begin
            w_we    = 1'b1;
            w_waddr = r_tl_addr;
            w_wdata = r_tl_data;
        end
    end

    // skip the old tail's link when the old tail is this process: its link
    // is cleared by the enqueue itself
    logic w_tail_link;
    assign w_tail_link = i_cmd.enq && r_head[w_q][EW-1] && !w_has_time
                         && r_tail[w_q][EW-1] && (r_tail[w_q][PW-1:0] != w_pid);

    logic [QW-1:0] w_pq;
    assign w_pq = r_pq[QW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
            r_next_run <= '0;
            r_last_ref <= '0;
            r_removed  <= 1'b0;
            r_pq       <= '0;
            r_steps    <= '0;
            r_prev     <= '0;
            r_node     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_req     <= i_req;
                r_removed <= 1'b0;
                r_prev    <= '0;
                r_node    <= r_head[QW'(i_req.priority_req)];
                r_steps   <= '0;
            end
            if (i_cmd.enq) begin
                if (!w_has_time) begin
                    r_last_ref <= w_me;
                end
                if (!r_head[w_q][EW-1]) begin
                    r_head[w_q] <= w_me;
                    r_tail[w_q] <= w_me;
                end else if (w_has_time) begin
                    r_head[w_q] <= w_me;
                end else begin
                    r_tail[w_q] <= w_me;
                end
            end
            if (i_cmd.walk_adv) begin
                r_prev  <= r_node;
                r_node  <= w_rdata;
                r_steps <= r_steps + 1'b1;
            end
            if (i_cmd.unlink) begin
                if (!r_prev[EW-1]) begin
                    r_head[w_q] <= w_rdata;
                end
                if (r_tail[w_q] == w_me) begin
                    r_tail[w_q] <= r_prev;
                end
                r_removed <= 1'b1;
            end
            if (i_cmd.pick_clr) begin
                r_pq <= '0;
            end
            if (i_cmd.pick_step) begin
                if (r_head[w_pq][EW-1]) begin
                    r_next_run <= r_head[w_pq];
                    r_pq       <= (QW+1)'(NUM_QUEUES);
                end else begin
                    r_pq <= r_pq + 1'b1;
                end
            end
        end
    end

    // register the tail link; it lands in the first pick cycle,
    // when the link RAM is otherwise idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl_we <= 1'b0;
        end else begin
            r_tl_we <= w_tail_link;
        end
        r_tl_addr <= r_tail[w_q][PW-1:0];
        r_tl_data <= w_me;
    end

    logic w_node_ok;
    assign w_node_ok = r_node[EW-1] && (32'(r_node[PW-1:0]) < NUM_PROCS);

    always_comb begin
        o_sts.req_ok    = w_pid_ok && w_q_ok;
        o_sts.is_deq    = r_req.func == FUNC_DEQ;
        o_sts.node_ok   = w_node_ok;
        o_sts.node_hit  = r_node[PW-1:0] == w_pid;
        o_sts.walk_end  = 32'(r_steps) >= NUM_PROCS;
        o_sts.need_pick = (r_req.current_valid && r_req.current_id == PID_W'(w_pid))
                          || r_next_run == w_me;
        o_sts.pick_end  = 32'(r_pq) >= NUM_QUEUES;
    end

    always_comb begin
        o_rsp = '0;
        if (w_pid_ok && w_q_ok) begin
            if (r_req.func == FUNC_ENQ) begin
                o_rsp.queue_used   = PRIO_W'(w_q);
                o_rsp.placed_front = w_has_time;
                o_rsp.ticks_after  = TICK_W'(w_has_time ? w_ticks_in : w_quant_in);
            end else begin
                o_rsp.removed = r_removed;
            end
        end
        o_rsp.next_id    = PID_W'(r_next_run[PW-1:0]);
        o_rsp.next_valid = r_next_run[EW-1];
    end
endmodule

### rtl/core/mlrq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlrq_ctrl
// Controller: sequences enqueue, dequeue walk, pick and result beat.
// ----------------------------------------------------------------------------
module mlrq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  mlrq_pkg::t_sts i_sts,
    output mlrq_pkg::t_cmd o_cmd,
    output logic           o_busy,
    output logic           o_valid
);
    import mlrq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_RD, S_CHK, S_UNLINK, S_PICK, S_DONE
    } t_state;

    t_state r_state;

    always_comb begin
        o_cmd = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_start;
        o_cmd.enq      = (r_state == S_DECODE) && i_sts.req_ok && !i_sts.is_deq;
        o_cmd.pick_clr = r_state == S_DECODE || r_state == S_UNLINK;
        o_cmd.walk_adv = (r_state == S_CHK) && i_sts.node_ok && !i_sts.node_hit
                         && !i_sts.walk_end;
        o_cmd.unlink   = r_state == S_UNLINK;
        o_cmd.pick_step = (r_state == S_PICK) && !i_sts.pick_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_busy  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_DECODE;
                        o_busy  <= 1'b1;
                    end
                end
                S_DECODE: begin
                    if (!i_sts.req_ok) begin
                        r_state <= S_DONE;
                    end else if (i_sts.is_deq) begin
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_PICK;
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (!i_sts.node_ok || i_sts.walk_end) begin
                        r_state <= S_DONE;
                    end else if (i_sts.node_hit) begin
                        r_state <= S_UNLINK;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_UNLINK: r_state <= i_sts.need_pick ? S_PICK : S_DONE;
                S_PICK: begin
                    if (i_sts.pick_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    o_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/core/multilevel_ready_queue_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_ready_queue_scheduler
// One linked ready queue per priority level over a fixed process table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Enqueue ends with
// a pick that scans one queue head per cycle; dequeue walks the link RAM, each
// link in a read state and a check state, and runs the pick scan only after
// removing the running or next process. The result beat is shown for one
// cycle with o_valid; the receiver cannot stall it, so capture it then.
module multilevel_ready_queue_scheduler #(
    parameter int unsigned NUM_QUEUES = 16,
    parameter int unsigned NUM_PROCS  = 64,
    parameter int unsigned TICK_BITS  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  mlrq_pkg::t_req i_req,
    output logic           o_valid,
    output mlrq_pkg::t_rsp o_rsp
);
    import mlrq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    t_rsp w_rsp;
    logic w_valid;

    mlrq_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd),
        .o_busy (busy),
        .o_valid(w_valid)
    );

    mlrq_dp #(
        .NUM_QUEUES(NUM_QUEUES),
        .NUM_PROCS (NUM_PROCS),
        .TICK_BITS (TICK_BITS)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .i_cmd  (w_cmd),
        .o_sts  (w_sts),
        .o_rsp  (w_rsp)
    );

    assign o_valid = w_valid;
    assign o_rsp   = w_rsp;
endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multilevel ready queue scheduler.
// ----------------------------------------------------------------------------
// A directed opener covers the field extremes, both operations and the corner
// cases: dequeue miss, dequeue of the running or next process, removal of the
// tail and of an interior node, and looping queues. Random traffic follows.
// Most of it is well-formed: processes not yet queued are enqueued, and queued
// ones are removed at their own level. The rest is random noise.
// A scoreboard class mirrors the queue state and predicts every result beat.
// ----------------------------------------------------------------------------
module tb;
    import mlrq_pkg::*;

    // Scoreboard: own copy of the queues, one expected beat per request.
    class sched_scoreboard;
        logic [6:0] head_q [16];
        logic [6:0] tail_q [16];
        logic [6:0] link_q [64];
        logic [6:0] next_run;
        logic [6:0] last_refill;
        t_rsp       expected_beats [$];
        int         errors;

        function new();
            for (int i = 0; i < 16; i++) begin
                head_q[i] = '0;
                tail_q[i] = '0;
            end
            for (int i = 0; i < 64; i++) link_q[i] = '0;
            next_run    = '0;
            last_refill = '0;
            errors      = 0;
        endfunction

        // Take the head of the lowest-numbered nonempty queue; keep it if none.
        function void pick_next();
            for (int q = 0; q < 16; q++) begin
                if (head_q[q][6]) begin
                    next_run = head_q[q];
                    return;
                end
            end
        endfunction

        task report(input string what, input logic [31:0] got, input logic [31:0] want);
            errors++;
            $display("MISMATCH %s: got %0h, want %0h", what, got, want);
        endtask

        // Note an accepted request: advance the mirrored state, queue its beat.
        function void note_request(input t_req r);
            t_rsp       beat;
            logic [6:0] me;
            logic [6:0] prev;
            logic [6:0] node;
            logic [5:0] pid;
            logic [3:0] q;
            logic [15:0] ticks;
            logic        has_time;
            beat  = '0;
            pid   = r.process_id;
            q     = r.priority_req;
            me    = {1'b1, pid};
            ticks = r.ticks_rem;
            if (t_func'(r.func) == FUNC_ENQ) begin
                has_time = (ticks != 0);
                if (!has_time) begin
                    ticks       = r.quantum;
                    last_refill = me;
                end
                beat.queue_used   = q;
                beat.placed_front = has_time;
                beat.ticks_after  = ticks;
                if (!head_q[q][6]) begin
                    head_q[q] = me;
                    tail_q[q] = me;
                    link_q[pid] = '0;
                end else if (has_time) begin
                    link_q[pid] = head_q[q];
                    head_q[q]   = me;
                end else begin
                    if (tail_q[q][6]) link_q[tail_q[q][5:0]] = me;
                    tail_q[q]   = me;
                    link_q[pid] = '0;
                end
                pick_next();
            end else begin
                prev = '0;
                node = head_q[q];
                for (int steps = 0; steps < 64 && node[6]; steps++) begin
                    if (node[5:0] == pid) begin
                        if (prev[6]) link_q[prev[5:0]] = link_q[pid];
                        else head_q[q] = link_q[pid];
                        if (tail_q[q] == me) tail_q[q] = prev;
                        beat.removed = 1'b1;
                        if ((r.current_valid && r.current_id == pid) || next_run == me)
                            pick_next();
                        break;
                    end
                    prev = node;
                    node = link_q[node[5:0]];
                end
            end
            beat.next_id    = next_run[5:0];
            beat.next_valid = next_run[6];
            expected_beats.push_back(beat);
        endfunction

        // Check one result beat against the oldest expectation.
        task check_result(input t_rsp got);
            t_rsp want;
            if (expected_beats.size() == 0) begin
                report("unexpected beat", 32'(got), 32'd0);
                return;
            end
            want = expected_beats.pop_front();
            if (got.queue_used !== want.queue_used)
                report("queue_used", 32'(got.queue_used), 32'(want.queue_used));
            if (got.placed_front !== want.placed_front)
                report("placed_front", 32'(got.placed_front), 32'(want.placed_front));
            if (got.ticks_after !== want.ticks_after)
                report("ticks_after", 32'(got.ticks_after), 32'(want.ticks_after));
            if (got.removed !== want.removed)
                report("removed", 32'(got.removed), 32'(want.removed));
            if (got.next_id !== want.next_id)
                report("next_id", 32'(got.next_id), 32'(want.next_id));
            if (got.next_valid !== want.next_valid)
                report("next_valid", 32'(got.next_valid), 32'(want.next_valid));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_valid;
    t_rsp o_rsp;

    sched_scoreboard sb;

    // Tb-side view of which processes sit in which queue, to shape traffic.
    bit         queued [64];
    logic [3:0] queued_level [64];
    bit         idle_on;

    multilevel_ready_queue_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Capture every result beat at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_rsp);
    end

    // Drive one request beat: hold start from a falling edge where busy is low
    // until the next falling edge, so it is taken at the rising edge between.
    task send_request(input t_req r);
        while (busy) @(negedge i_clk);
        start = 1'b1;
        i_req = r;
        @(negedge i_clk);
        start = 1'b0;
        sb.note_request(r);
        if (t_func'(r.func) == FUNC_ENQ) begin
            queued[r.process_id]       = 1'b1;
            queued_level[r.process_id] = r.priority_req;
        end else if (queued_level[r.process_id] == r.priority_req) begin
            queued[r.process_id] = 1'b0;
        end
        if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    task send_op(input t_func f, input int pid, input int prio, input int ticks,
                 input int quantum, input int cur, input bit cur_valid);
        t_req r;
        r.func          = f;
        r.process_id    = 6'(pid);
        r.priority_req  = 4'(prio);
        r.ticks_rem     = 16'(ticks);
        r.quantum       = 16'(quantum);
        r.current_id    = 6'(cur);
        r.current_valid = cur_valid;
        send_request(r);
    endtask

    // Random request: mostly well-formed enqueues and dequeues, some noise.
    task send_random();
        t_req r;
        int   pid;
        int   pick;
        r      = '0;
        pick   = $urandom_range(0, 99);
        pid    = $urandom_range(0, 63);
        r.ticks_rem     = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
        r.quantum       = 16'($urandom);
        r.current_id    = 6'($urandom_range(0, 63));
        r.current_valid = 1'($urandom_range(0, 1));
        if (pick < 45) begin
            for (int k = 0; k < 8 && queued[pid]; k++) pid = $urandom_range(0, 63);
            r.func         = FUNC_ENQ;
            r.process_id   = 6'(pid);
            r.priority_req = $urandom_range(0, 3) == 0 ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(0, 3));
        end else if (pick < 88) begin
            for (int k = 0; k < 16 && !queued[pid]; k++) pid = $urandom_range(0, 63);
            r.func         = FUNC_DEQ;
            r.process_id   = 6'(pid);
            r.priority_req = queued_level[pid];
            if ($urandom_range(0, 2) == 0) begin
                r.current_id    = 6'(pid);
                r.current_valid = 1'b1;
            end
        end else begin
            r.func         = 1'($urandom_range(0, 1));
            r.process_id   = 6'(pid);
            r.priority_req = 4'($urandom_range(0, 15));
        end
        send_request(r);
    endtask

    initial begin
        sb      = new();
        start   = 1'b0;
        i_req   = '0;
        i_rst_n = 1'b0;
        idle_on = 1'b0;
        for (int i = 0; i < 64; i++) begin
            queued[i]       = 1'b0;
            queued_level[i] = '0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed opener.
        send_op(FUNC_DEQ, 5, 3, 0, 0, 0, 0);               // dequeue from empty queue
        send_op(FUNC_ENQ, 0, 15, 16'hFFFF, 0, 0, 0);       // head insert, max ticks
        send_op(FUNC_ENQ, 63, 15, 0, 16'hFFFF, 63, 1);     // refill, tail insert
        send_op(FUNC_ENQ, 7, 0, 0, 0, 0, 0);               // refill from zero quantum
        send_op(FUNC_ENQ, 8, 0, 1, 16'h5555, 0, 0);        // head of queue 0
        send_op(FUNC_ENQ, 9, 0, 0, 16'hAAAA, 0, 0);        // tail of queue 0
        send_op(FUNC_DEQ, 33, 0, 0, 0, 0, 0);              // walk misses
        send_op(FUNC_DEQ, 9, 0, 16'hFFFF, 16'hFFFF, 0, 0); // remove the tail
        send_op(FUNC_DEQ, 8, 0, 0, 0, 63, 1);              // remove picked next
        send_op(FUNC_ENQ, 8, 0, 2, 0, 0, 0);
        send_op(FUNC_ENQ, 10, 0, 0, 3, 0, 0);
        send_op(FUNC_DEQ, 7, 0, 0, 0, 7, 1);               // remove interior, running
        send_op(FUNC_DEQ, 10, 0, 0, 0, 0, 0);
        send_op(FUNC_DEQ, 8, 0, 0, 0, 0, 0);               // queue 0 drains
        send_op(FUNC_DEQ, 63, 15, 0, 0, 63, 1);
        send_op(FUNC_DEQ, 0, 15, 0, 0, 0, 0);              // all empty, next kept
        send_op(FUNC_ENQ, 21, 14, 4, 4, 0, 0);             // self loop: re-enqueue at head
        send_op(FUNC_ENQ, 21, 14, 4, 4, 0, 0);
        send_op(FUNC_DEQ, 22, 14, 0, 0, 0, 0);             // walk stops at the step limit
        send_op(FUNC_DEQ, 21, 14, 0, 0, 21, 1);            // unlink leaves head valid, no tail
        send_op(FUNC_ENQ, 23, 14, 0, 9, 0, 0);             // tail append with no tail
        queued[21] = 1'b1;
        queued_level[21] = 4'd14;

        // Random traffic; idling on for most of it, off at the end.
        idle_on = 1'b1;
        for (int n = 0; n < 530; n++) begin
            if (n == 450) idle_on = 1'b0;
            send_random();
        end

        // Drain, then allow the longest walk to finish.
        while (sb.expected_beats.size() != 0) @(negedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard limit well beyond the slowest correct run.
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
